@@ sv/pdlq_pkg.sv @@
// Shared types and constants for the packet delay and loss queue.
package pdlq_pkg;

  localparam int LEN_W = 12;
  localparam int DELAY_W = 26;
  localparam int THR_W = 17;
  localparam int MAX_PACKET_BYTES = 2048;
  localparam int US_PER_MS = 1000;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_POLL = 1'b1;

  typedef struct packed {
    logic              op;
    logic [19:0]       elapsed_us;
    logic              arrived;
    logic [LEN_W-1:0]  packet_length;
    logic [15:0]       packet_handle;
    logic [31:0]       source_addr;
    logic [15:0]       source_port;
    logic [15:0]       loss_draw;
    logic [15:0]       lag_ms;
  } in_item_t;

  typedef struct packed {
    logic              released;
    logic [LEN_W-1:0]  out_length;
    logic [15:0]       out_handle;
    logic [31:0]       out_addr;
    logic [15:0]       out_port;
    logic              dropped_full;
  } out_item_t;

  typedef struct packed {
    logic [LEN_W-1:0]  length;
    logic [15:0]       handle;
    logic [31:0]       addr;
    logic [15:0]       port;
  } entry_t;

  typedef struct packed {
    logic capture;
    logic tick;
    logic insert;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic is_poll;
    logic out_busy;
  } sts_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_APPLY,
    ST_EMIT
  } state_e;

endpackage

@@ sv/pdlq_ctrl.sv @@
// Controller state machine sequencing capture, queue update and result transfer.
module pdlq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  pdlq_pkg::sts_t  sts_i,
  output pdlq_pkg::cmd_t  cmd_o
);

  pdlq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pdlq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      pdlq_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = pdlq_pkg::ST_APPLY;
        end
      end
      pdlq_pkg::ST_APPLY: begin
        if (sts_i.is_poll) begin
          cmd_o.insert = 1'b1;
          state_d      = pdlq_pkg::ST_EMIT;
        end else begin
          cmd_o.tick = 1'b1;
          state_d    = pdlq_pkg::ST_IDLE;
        end
      end
      pdlq_pkg::ST_EMIT: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = pdlq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pdlq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ sv/pdlq_datapath.sv @@
// Datapath: capture register, sorted row of queue cells and output register.
module pdlq_datapath #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  pdlq_pkg::in_item_t               in_data_i,
  input  logic                             cfg_valid_i,
  input  logic [pdlq_pkg::THR_W-1:0]       cfg_data_i,
  input  pdlq_pkg::cmd_t                   cmd_i,
  output pdlq_pkg::sts_t                   sts_o,
  input  logic                             out_stall_i,
  output logic                             out_valid_o,
  output pdlq_pkg::out_item_t              out_data_o
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int DW = pdlq_pkg::DELAY_W;

  pdlq_pkg::in_item_t            item_q;
  logic [DW-1:0]                 lag_us_q;
  logic [pdlq_pkg::THR_W-1:0]    thr_q;
  logic [CW-1:0]                 occ_q, occ_d;
  logic [DW-1:0]                 delay_q [QUEUE_DEPTH];
  logic [DW-1:0]                 delay_d [QUEUE_DEPTH];
  pdlq_pkg::entry_t              entry_q [QUEUE_DEPTH];
  pdlq_pkg::entry_t              entry_d [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]        le;
  logic                          dropped_q, dropped_d;
  logic                          out_valid_q, out_valid_d;
  pdlq_pkg::out_item_t           out_data_q, out_data_d;
  logic                          full, take, do_insert, head_ready, do_pop;
  logic [DW-1:0]                 elapsed_ext;
  pdlq_pkg::entry_t              new_entry;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q   <= in_data_i;
      lag_us_q <= DW'(in_data_i.lag_ms) * DW'(pdlq_pkg::US_PER_MS);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (cfg_valid_i) begin
      thr_q <= cfg_data_i;
    end
  end

  assign full        = occ_q == CW'(QUEUE_DEPTH);
  assign take        = item_q.arrived && (item_q.packet_length != '0) &&
                       ({1'b0, item_q.loss_draw} >= thr_q);
  assign do_insert   = cmd_i.insert && take && !full;
  assign head_ready  = (occ_q != '0) && (delay_q[0] == '0);
  assign do_pop      = cmd_i.emit && head_ready;
  assign elapsed_ext = DW'(item_q.elapsed_us);

  always_comb begin
    new_entry        = '0;
    new_entry.handle = item_q.packet_handle;
    new_entry.addr   = item_q.source_addr;
    new_entry.port   = item_q.source_port;
    if ({4'b0, item_q.packet_length} > 16'(pdlq_pkg::MAX_PACKET_BYTES)) begin
      new_entry.length = pdlq_pkg::LEN_W'(pdlq_pkg::MAX_PACKET_BYTES);
    end else begin
      new_entry.length = item_q.packet_length;
    end
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    assign le[i] = (CW'(i) < occ_q) && (delay_q[i] <= lag_us_q);

    always_comb begin
      delay_d[i] = delay_q[i];
      entry_d[i] = entry_q[i];
      if (cmd_i.tick) begin
        if (delay_q[i] > elapsed_ext) begin
          delay_d[i] = delay_q[i] - elapsed_ext;
        end else begin
          delay_d[i] = '0;
        end
      end else if (do_insert) begin
        if (!le[i]) begin
          if (i == 0) begin
            delay_d[i] = lag_us_q;
            entry_d[i] = new_entry;
          end else if (le[(i == 0) ? 0 : i - 1]) begin
            delay_d[i] = lag_us_q;
            entry_d[i] = new_entry;
          end else begin
            delay_d[i] = delay_q[(i == 0) ? 0 : i - 1];
            entry_d[i] = entry_q[(i == 0) ? 0 : i - 1];
          end
        end
      end else if (do_pop) begin
        if (i < QUEUE_DEPTH - 1) begin
          delay_d[i] = delay_q[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
          entry_d[i] = entry_q[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      delay_q[i] <= delay_d[i];
      entry_q[i] <= entry_d[i];
    end
  end

  always_comb begin
    occ_d = occ_q;
    if (do_insert) begin
      occ_d = occ_q + CW'(1);
    end else if (do_pop) begin
      occ_d = occ_q - CW'(1);
    end
  end

  always_comb begin
    dropped_d = dropped_q;
    if (cmd_i.insert) begin
      dropped_d = take && full;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    if (cmd_i.emit) begin
      out_valid_d             = 1'b1;
      out_data_d              = '0;
      out_data_d.dropped_full = dropped_q;
      if (head_ready) begin
        out_data_d.released   = 1'b1;
        out_data_d.out_length = entry_q[0].length;
        out_data_d.out_handle = entry_q[0].handle;
        out_data_d.out_addr   = entry_q[0].addr;
        out_data_d.out_port   = entry_q[0].port;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      occ_q       <= occ_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dropped_q  <= dropped_d;
    out_data_q <= out_data_d;
  end

  assign sts_o.is_poll  = item_q.op == pdlq_pkg::OP_POLL;
  assign sts_o.out_busy = out_valid_q && out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_data_q;

endmodule

@@ sv/packet_delay_loss_queue.sv @@
// Top level of the packet delay and loss queue: controller plus datapath.
//
//   channel   direction  handshake              payload
//   in        input      in_valid_i/in_stall_o  in_data_i  (pdlq_pkg::in_item_t)
//   out       output     out_valid_o/out_stall_i out_data_o (pdlq_pkg::out_item_t)
//   cfg       input      cfg_valid_i/cfg_ready_o cfg_data_i (loss threshold)
//
// A tick captures the item with the lag multiply, then applies the saturating
// subtract in every queue cell. A poll captures, does the sorted insert into
// the cell row, then releases into the output register; the release waits
// while the output register is still held by a stalled transfer.
// Reset clears the queue occupancy, the threshold and the output valid.
module packet_delay_loss_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  pdlq_pkg::in_item_t          in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output pdlq_pkg::out_item_t         out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [pdlq_pkg::THR_W-1:0]  cfg_data_i
);

  pdlq_pkg::cmd_t cmd;
  pdlq_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  pdlq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pdlq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

`ifndef NO_ASSERTIONS
  a_stall_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled while an item is in work");

  a_emit_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> !sts.out_busy)
    else $error("result loaded over a stalled output");

  a_valid_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.emit))
    else $error("output valid without a release step");
`endif

endmodule
